// ===== hw/rtl/bba_pkg.sv =====
// Shared types, codes and constants of the bitmap block allocator.
package bba_pkg;

  // Fixed field widths.
  localparam int BLK_W = 12;
  localparam int CNT_W = 13;
  localparam logic [CNT_W-1:0] CNT_RESET = 13'd4096;

  // Default geometry of the free map.
  localparam int DEF_MAX_BLOCKS = 4096;
  localparam int DEF_WORD_BITS  = 64;

  // Shift of the reciprocal used to split a block number into word and bit.
  localparam int DIV_SH = 20;

  // Operation codes.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_RANGE  = 2'd3
  } status_e;

  typedef struct packed {
    logic             func;
    logic [BLK_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic [BLK_W-1:0] allocated_block;
    logic [1:0]       status;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clear;
    logic    load;
    logic    scan;
    logic    alloc_wr;
    logic    mul;
    logic    fix;
    logic    fr_rd;
    logic    free_wr;
    logic    emit;
    logic    take_blk;
    status_e st;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic hit;
    logic exhausted;
    logic out_range;
    logic fr_set;
  } sts_t;

endpackage

// ===== hw/rtl/bba_ctrl.sv =====
// Controller state machine of the bitmap block allocator.
module bba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          func_i,
  input  bba_pkg::sts_t sts_i,
  output bba_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC,
    S_FR_MUL,
    S_FR_FIX,
    S_FR_RD,
    S_FR_CHK
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  logic   done_q;

  // Next state and command decode.
  always_comb begin
    cmd_o    = '0;
    cmd_o.st = bba_pkg::ST_OK;
    state_d  = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = (func_i == bba_pkg::FUNC_FREE) ? S_FR_MUL : S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit) begin
          cmd_o.alloc_wr = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.take_blk = 1'b1;
          cmd_o.st       = bba_pkg::ST_OK;
          state_d        = S_IDLE;
        end else if (sts_i.exhausted) begin
          cmd_o.emit = 1'b1;
          cmd_o.st   = bba_pkg::ST_FULL;
          state_d    = S_IDLE;
        end
      end
      S_FR_MUL: begin
        if (sts_i.out_range) begin
          cmd_o.emit = 1'b1;
          cmd_o.st   = bba_pkg::ST_RANGE;
          state_d    = S_IDLE;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = S_FR_FIX;
        end
      end
      S_FR_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_FR_RD;
      end
      S_FR_RD: begin
        cmd_o.fr_rd = 1'b1;
        state_d     = S_FR_CHK;
      end
      S_FR_CHK: begin
        cmd_o.emit = 1'b1;
        if (sts_i.fr_set) begin
          cmd_o.free_wr = 1'b1;
          cmd_o.st      = bba_pkg::ST_OK;
        end else begin
          cmd_o.st = bba_pkg::ST_DOUBLE;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
      done_q  <= cmd_o.emit;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// ===== hw/rtl/bba_dpath.sv =====
// Datapath of the bitmap block allocator: free map memory, scan, index split, result.
module bba_dpath #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
  parameter int WORD_BITS  = bba_pkg::DEF_WORD_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bba_pkg::cmd_t               cmd_i,
  input  logic [bba_pkg::BLK_W-1:0]   bn_i,
  input  logic                        cfg_valid_i,
  input  logic [bba_pkg::CNT_W-1:0]   cfg_data_i,
  output bba_pkg::sts_t               sts_o,
  output bba_pkg::rsp_t               rsp_o
);

  localparam int CNT_W     = bba_pkg::CNT_W;
  localparam int BLK_W     = bba_pkg::BLK_W;
  localparam int BASE_W    = CNT_W + 1;
  localparam int CNT_MAX   = (2 ** CNT_W) - 1;
  localparam int USE_BLOCKS = (MAX_BLOCKS < CNT_MAX) ? MAX_BLOCKS : CNT_MAX;
  localparam int MAP_WORDS = (USE_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int OFF_W     = $clog2(WORD_BITS);
  localparam int SH        = bba_pkg::DIV_SH;
  localparam int RECIP     = (2 ** SH) / WORD_BITS;
  localparam int PROD_W    = SH + BLK_W;
  localparam int QW_W      = BLK_W + 7;

  // Block count register and effective limit.
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= bba_pkg::CNT_RESET;
    end else if (cfg_valid_i) begin
      cnt_q <= cfg_data_i;
    end
  end

  assign lim = (cnt_q > CNT_W'(USE_BLOCKS)) ? CNT_W'(USE_BLOCKS) : cnt_q;

  // Free map memory, one write and one registered read port.
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] mem_rd_q;
  logic [AW-1:0]        rd_sel;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // Scan pipeline registers.
  logic [AW-1:0]     rd_addr_q;
  logic [BASE_W-1:0] rd_base_q;
  logic              chk_vld_q;
  logic [AW-1:0]     chk_addr_q;
  logic [CNT_W-1:0]  chk_base_q;
  logic [CNT_W-1:0]  chk_rem_q;

  // Free path registers.
  logic [BLK_W-1:0]  bn_q;
  logic [BLK_W-1:0]  qe_q;
  logic [AW-1:0]     fr_word_q;
  logic [OFF_W-1:0]  fr_off_q;

  bba_pkg::rsp_t     rsp_q;

  // Lowest usable clear bit of the word under check.
  logic                 can_issue;
  logic [WORD_BITS-1:0] vmask;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] low_bit;
  logic [OFF_W-1:0]     low_idx;
  logic                 hit;
  logic [CNT_W-1:0]     hit_blk;

  assign can_issue = (rd_base_q < {1'b0, lim});

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      vmask[i] = (CNT_W'(i) < chk_rem_q);
    end
    free_bits = ~mem_rd_q & vmask;
    low_bit   = free_bits & (~free_bits + WORD_BITS'(1));
    for (int i = 0; i < WORD_BITS; i++) begin
      low_idx = low_idx | (low_bit[i] ? OFF_W'(i) : OFF_W'(0));
    end
  end

  assign hit     = chk_vld_q & (|free_bits);
  assign hit_blk = chk_base_q + CNT_W'(low_idx);

  // Reciprocal multiply and remainder correction for the free index.
  logic [PROD_W-1:0] prod;
  logic [QW_W-1:0]   qw;
  logic [CNT_W-1:0]  rem_raw;
  logic [BLK_W-1:0]  word_n;
  logic [CNT_W-1:0]  off_n;

  always_comb begin
    prod    = PROD_W'(bn_q) * PROD_W'(RECIP);
    qw      = QW_W'(qe_q) * QW_W'(WORD_BITS);
    rem_raw = CNT_W'(bn_q) - CNT_W'(qw);
    if (rem_raw >= CNT_W'(WORD_BITS)) begin
      word_n = qe_q + BLK_W'(1);
      off_n  = rem_raw - CNT_W'(WORD_BITS);
    end else begin
      word_n = qe_q;
      off_n  = rem_raw;
    end
  end

  // Scan and clear counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
      rd_base_q <= '0;
      chk_vld_q <= 1'b0;
    end else if (cmd_i.clear) begin
      rd_addr_q <= rd_addr_q + AW'(1);
    end else if (cmd_i.load) begin
      rd_addr_q <= '0;
      rd_base_q <= '0;
      chk_vld_q <= 1'b0;
    end else if (cmd_i.scan) begin
      if (can_issue && !hit) begin
        rd_addr_q <= rd_addr_q + AW'(1);
        rd_base_q <= rd_base_q + BASE_W'(WORD_BITS);
        chk_vld_q <= 1'b1;
      end else begin
        chk_vld_q <= 1'b0;
      end
    end
  end

  // Payload that follows each issued word into the check stage.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      chk_addr_q <= rd_addr_q;
      chk_base_q <= rd_base_q[CNT_W-1:0];
      chk_rem_q  <= lim - rd_base_q[CNT_W-1:0];
    end
  end

  // Free path: latch block number, estimate quotient, then correct.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bn_q <= bn_i;
    end
    if (cmd_i.mul) begin
      qe_q <= prod[PROD_W-1:SH];
    end
    if (cmd_i.fix) begin
      fr_word_q <= AW'(word_n);
      fr_off_q  <= OFF_W'(off_n);
    end
  end

  // Memory port selection.
  always_comb begin
    rd_sel  = cmd_i.fr_rd ? fr_word_q : rd_addr_q;
    wr_en   = cmd_i.clear | cmd_i.alloc_wr | cmd_i.free_wr;
    wr_addr = rd_addr_q;
    wr_data = '0;
    if (cmd_i.alloc_wr) begin
      wr_addr = chk_addr_q;
      wr_data = mem_rd_q | low_bit;
    end else if (cmd_i.free_wr) begin
      wr_addr = fr_word_q;
      wr_data = mem_rd_q & ~(WORD_BITS'(1) << fr_off_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    mem_rd_q <= map_mem[rd_sel];
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rsp_q.status          <= cmd_i.st;
      rsp_q.allocated_block <= cmd_i.take_blk ? hit_blk[BLK_W-1:0] : '0;
    end
  end

  assign sts_o.clr_last  = (rd_addr_q == AW'(MAP_WORDS - 1));
  assign sts_o.hit       = hit;
  assign sts_o.exhausted = !can_issue && !hit;
  assign sts_o.out_range = ({1'b0, bn_q} >= lim);
  assign sts_o.fr_set    = mem_rd_q[fr_off_q];
  assign rsp_o           = rsp_q;

endmodule

// ===== hw/rtl/bitmap_block_allocator_unit.sv =====
// Top level of the first-fit bitmap block allocator.
//
//   channel   signals                          direction  transaction when
//   request   start, busy, req_i               in         start high and busy low
//   result    done_o, rsp_o                    out        done_o high (one cycle)
//   config    cfg_valid_i, cfg_ready_o,        in         cfg_valid_i and cfg_ready_o
//             cfg_data_i
//
// After reset a clearing pass zeroes all ceil(min(MAX_BLOCKS, 8191) / WORD_BITS)
// words of the free map (64 by default), one word a cycle, with busy high.
// An allocate reads the map words in turn, one word per cycle through the single
// read port of the map memory, until a clear bit is found or the usable words run
// out (at most 64 words by default); then the result strobe is raised.
// A free passes the multiply, correct, read and check states, or ends in the first
// when the index is out of range. Results cannot be stalled; the next request may
// be accepted in the cycle its predecessor's result is shown.
module bitmap_block_allocator_unit #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
  parameter int WORD_BITS  = bba_pkg::DEF_WORD_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  bba_pkg::req_t              req_i,
  output logic                       done_o,
  output bba_pkg::rsp_t              rsp_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bba_pkg::CNT_W-1:0]  cfg_data_i
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  // The count register is always ready to take a write.
  assign cfg_ready_o = 1'b1;

  bba_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (req_i.func),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  bba_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .WORD_BITS  (WORD_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .bn_i        (req_i.block_number),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== hw/rtl/bba_checker.sv =====
// Port-level checker of the bitmap block allocator and its bind statement.
module bba_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input bba_pkg::rsp_t rsp_o
);

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // One request gives one result: strobes never come back to back.
  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // A result is only shown right after the block has been working.
  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // Every request that fails returns a zero block index.
  a_zero_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status != bba_pkg::ST_OK) |-> (rsp_o.allocated_block == '0))
    else $error("failed request returned a nonzero block index");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

// ===== tb/sv/bba_alloc_checker.sv =====
// Checker for the bitmap block allocator: tracks the free map, predicts results, compares.
module bba_alloc_checker
  import bba_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  req_t             req_i,
  input  logic             done_o,
  input  rsp_t             rsp_o,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i,
  output int               mismatch_count,
  output int               pending_count
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = DEF_MAX_BLOCKS;

  // Our own copy of the allocation state and the block count register.
  logic [CAPACITY-1:0] in_use_map;
  logic [CNT_W-1:0]    block_count_reg;
  rsp_t                expected_rsp_q[$];

  // Apply one request to the shadow map and return the response it should give.
  function automatic rsp_t predict_response(input req_t r);
    int   usable;
    rsp_t res;
    usable = (int'(block_count_reg) > CAPACITY) ? CAPACITY : int'(block_count_reg);
    res = '0;
    if (r.func == FUNC_ALLOC) begin
      // First fit: claim the lowest clear bit below the usable count.
      res.status = ST_FULL;
      for (int b = 0; b < usable; b++) begin
        if (!in_use_map[b]) begin
          in_use_map[b]       = 1'b1;
          res.allocated_block = BLK_W'(b);
          res.status          = ST_OK;
          break;
        end
      end
    end else if (int'(r.block_number) >= usable) begin
      res.status = ST_RANGE;
    end else if (!in_use_map[r.block_number]) begin
      res.status = ST_DOUBLE;
    end else begin
      in_use_map[r.block_number] = 1'b0;
      res.status = ST_OK;
    end
    return res;
  endfunction

  // Watch all three channels. A result is retired before a request accepted
  // at the same edge is predicted, since it belongs to an earlier request.
  always @(posedge clk_i or negedge rst_ni) begin : track
    rsp_t exp_rsp;
    if (!rst_ni) begin
      in_use_map      = '0;
      block_count_reg = CNT_RESET;
      expected_rsp_q.delete();
      mismatch_count  = 0;
      pending_count   = 0;
    end else begin
      if (done_o) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got block %0d status %0d",
                   $time, rsp_o.allocated_block, rsp_o.status);
          mismatch_count++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (rsp_o.allocated_block !== exp_rsp.allocated_block) begin
            $display("%0t: allocated_block mismatch, expected %0d, got %0d",
                     $time, exp_rsp.allocated_block, rsp_o.allocated_block);
            mismatch_count++;
          end
          if (rsp_o.status !== exp_rsp.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, exp_rsp.status, rsp_o.status);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        block_count_reg = cfg_data_i;
      end
      if (start && !busy) begin
        expected_rsp_q.push_back(predict_response(req_i));
      end
      pending_count = expected_rsp_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_bitmap_block_allocator_unit.sv =====
// Testbench top for the bitmap block allocator: clock, reset, stimulus and verdict.
module tb_bitmap_block_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 115;
  localparam int NUM_PHASES  = 15;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  req_t             req_i;
  logic             done_o;
  rsp_t             rsp_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i;
  int               mismatch_count;
  int               pending_count;
  int               stall_cycles = 0;
  int               cur_count = int'(CNT_RESET);

  // Block counts of the random phases, the extremes among them.
  int phase_counts[NUM_PHASES] = '{37, 64, 1, 130, 8191, 200, 63, 4095, 65, 12,
                                   4096, 0, 500, 129, 7};

  bitmap_block_allocator_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  bba_alloc_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .done_o         (done_o),
    .rsp_o          (rsp_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: end the run if no transaction happens on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Issue one request; called at a falling edge and returns at one. Start stays
  // high after acceptance so that a back-to-back request does not toggle it.
  task automatic issue(input req_t r, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      req_i <= req_t'($urandom);
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic issue_op(input logic func, input int blk);
    req_t r;
    r.func         = func;
    r.block_number = BLK_W'(blk);
    issue(r, 0);
  endtask

  // Write the block count once every outstanding result has come back.
  task automatic write_block_count(input int value);
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0 || busy) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= CNT_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_count = value;
  endtask

  // Mostly allocations and frees of nearby blocks, with some frees anywhere.
  function automatic req_t random_request(input int count);
    req_t r;
    int   usable;
    int   pick;
    int   hi;
    usable = (count > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : count;
    pick   = $urandom_range(99);
    r.block_number = BLK_W'($urandom);
    if (pick < 55) begin
      r.func = FUNC_ALLOC;
    end else begin
      r.func = FUNC_FREE;
      if (pick < 95) begin
        if (usable == 0) hi = 3;
        else hi = (usable > 700) ? 700 : usable + 1;
        r.block_number = BLK_W'($urandom_range(hi));
      end
    end
    return r;
  endfunction

  initial begin
    int item_idx;
    int idle_pct;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset count: first fit, plain free and double free.
    issue_op(FUNC_ALLOC, 4095);
    issue_op(FUNC_ALLOC, 0);
    issue_op(FUNC_FREE, 0);
    issue_op(FUNC_FREE, 0);
    issue_op(FUNC_FREE, 4095);
    issue_op(FUNC_ALLOC, 0);
    issue_op(FUNC_FREE, 1);
    issue_op(FUNC_ALLOC, 2048);

    // Zero count: allocate is out of blocks and every free is out of range.
    write_block_count(0);
    issue_op(FUNC_ALLOC, 0);
    issue_op(FUNC_FREE, 0);
    issue_op(FUNC_FREE, 4095);

    // A count above capacity saturates to the full map.
    write_block_count(8191);
    issue_op(FUNC_FREE, 4095);
    issue_op(FUNC_ALLOC, 4095);

    // Lowered count: block 2 stays set and cannot be freed, the map fills.
    write_block_count(2);
    issue_op(FUNC_ALLOC, 0);
    issue_op(FUNC_FREE, 2);
    issue_op(FUNC_FREE, 1);
    issue_op(FUNC_ALLOC, 0);
    issue_op(FUNC_ALLOC, 0);

    // Raising the count again makes the stranded block reachable.
    write_block_count(3);
    issue_op(FUNC_FREE, 2);
    issue_op(FUNC_ALLOC, 0);
    issue_op(FUNC_ALLOC, 0);

    // Random phases, one block count each; the sender's idling varies by thirds.
    item_idx = 0;
    foreach (phase_counts[p]) begin
      write_block_count(phase_counts[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (item_idx < NUM_PHASES * PHASE_ITEMS / 3) idle_pct = 28;
        else if (item_idx < 2 * NUM_PHASES * PHASE_ITEMS / 3) idle_pct = 61;
        else idle_pct = 0;
        issue(random_request(cur_count), idle_pct);
        item_idx++;
      end
    end
    start <= 1'b0;

    // Drain, let the block settle, then give the verdict.
    while (pending_count != 0) @(negedge clk_i);
    repeat (80) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
